FILE: hdl/dda_pkg.sv
// ----------------------------------------------------------------------------
// DDA raycaster shared definitions
// Screen and map geometry, fixed-point widths, register indexes, the beat
// types that pass between the front queue, the walk engine and the divider.
// ----------------------------------------------------------------------------
package dda_pkg;

   // Geometry.
   localparam int SCREEN_WIDTH  = 640;
   localparam int SCREEN_HEIGHT = 480;
   localparam int HALF_HEIGHT   = SCREEN_HEIGHT / 2;
   localparam int MAP_SIZE      = 32;
   localparam int MAP_BITS      = 5;
   localparam int ADDR_BITS     = 2 * MAP_BITS;
   localparam int CELL_COUNT    = MAP_SIZE * MAP_SIZE;
   localparam int STEP_LIMIT    = 2 * MAP_SIZE;
   localparam int STEP_BITS     = 7;

   // Fixed point.
   localparam int ONE_Q16    = 65536;
   localparam int CAM_W      = 19;
   localparam int RAY_W      = 21;
   localparam int ABS_W      = 20;
   localparam int FRAC_W     = 17;
   localparam int DELTA_W    = 33;
   localparam int DIST_W     = 40;
   localparam logic [DELTA_W-1:0] DELTA_SAT = {1'b1, {(DELTA_W-1){1'b0}}};
   localparam logic [DELTA_W-1:0] LINE_DIVIDEND = DELTA_W'(SCREEN_HEIGHT * ONE_Q16);

   // The view offset floor(2*col*ONE/SCREEN_WIDTH) - ONE is split into a
   // whole part and a reciprocal multiply for the remainder.
   localparam int CAM_WHOLE        = 2 * ONE_Q16 / SCREEN_WIDTH;
   localparam int CAM_REM          = 2 * ONE_Q16 % SCREEN_WIDTH;
   localparam int CAM_RECIP_SHIFT  = 29;
   localparam int CAM_RECIP        = (2**29 + SCREEN_WIDTH - 1) / SCREEN_WIDTH;

   // Divider.
   localparam int DIV_STEPS = DELTA_W;
   localparam int DIV_CNT_W = 6;

   // Input queue.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_BITS  = 2;

   // Register indexes.
   localparam logic [2:0] CSR_POSITION_X     = 3'd0;
   localparam logic [2:0] CSR_POSITION_Y     = 3'd1;
   localparam logic [2:0] CSR_DIRECTION_X    = 3'd2;
   localparam logic [2:0] CSR_DIRECTION_Y    = 3'd3;
   localparam logic [2:0] CSR_CAMERA_PLANE_X = 3'd4;
   localparam logic [2:0] CSR_CAMERA_PLANE_Y = 3'd5;

   typedef enum logic {
      KIND_WRITE,
      KIND_CAST
   } item_kind_type;

   typedef enum logic [3:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_CAM,
      BK_RAY,
      BK_XGO,
      BK_XWAIT,
      BK_YGO,
      BK_YWAIT,
      BK_SIDE_LO,
      BK_SIDE_HI,
      BK_STEP,
      BK_CHECK,
      BK_LINE,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic       op;
      logic [9:0] screen_column;
      logic [4:0] cell_x;
      logic [4:0] cell_y;
      logic [3:0] cell_value;
   } item_type;

   typedef struct packed {
      item_kind_type kind;
      logic [9:0]    screen_column;
      logic [4:0]    cell_x;
      logic [4:0]    cell_y;
      logic [3:0]    cell_value;
   } work_type;

   typedef struct packed {
      logic [23:0]        position_x;
      logic [23:0]        position_y;
      logic signed [17:0] direction_x;
      logic signed [17:0] direction_y;
      logic signed [17:0] camera_plane_x;
      logic signed [17:0] camera_plane_y;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic [DELTA_W-1:0] dividend;
      logic [DIST_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic [DELTA_W-1:0] quotient;
   } div_rsp_type;

   // Wall color for a nonzero cell value.
   function automatic logic [23:0] pick_color(input logic [3:0] value);
      logic [23:0] color;
      case (value)
         4'd1:    color = 24'hFF0000;
         4'd2:    color = 24'h00FF00;
         4'd3:    color = 24'h0000FF;
         4'd4:    color = 24'hFFFFFF;
         default: color = 24'hFFFF00;
      endcase
      return color;
   endfunction

endpackage

FILE: hdl/dda_raycast_column.sv
// ----------------------------------------------------------------------------
// DDA raycaster, one wall span per screen column
// A cast uses the shared one-bit-per-cycle divider in up to three passes
// and the walk loop, with one map read per step.
// Synchronous reset clears the control state and starts a pass that zeroes
// all 1024 map cells; requests are held off until it ends.
// ----------------------------------------------------------------------------
module dda_raycast_column (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_op,
   input  logic [9:0]  req_screen_column,
   input  logic [4:0]  req_cell_x,
   input  logic [4:0]  req_cell_y,
   input  logic [3:0]  req_cell_value,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [9:0]  rsp_column_out,
   output logic [8:0]  rsp_span_start,
   output logic [8:0]  rsp_span_end,
   output logic [23:0] rsp_wall_color,
   output logic        rsp_hit_side,
   output logic        rsp_hit_found,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);
   import dda_pkg::*;

   logic [23:0]  position_x_ff, position_y_ff;
   logic [17:0]  direction_x_ff, direction_y_ff;
   logic [17:0]  camera_plane_x_ff, camera_plane_y_ff;
   cfg_type      cfg;
   item_type     item;
   work_type     deq_work;
   logic         deq_valid;
   logic         deq_ready;
   logic         clearing;
   div_req_type  div_req;
   div_rsp_type  div_rsp;

   // Configuration registers, always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         position_x_ff     <= '0;
         position_y_ff     <= '0;
         direction_x_ff    <= 18'h30000;
         direction_y_ff    <= '0;
         camera_plane_x_ff <= '0;
         camera_plane_y_ff <= 18'd43254;
      end else if (csr_valid & csr_ready) begin
         case (csr_index)
            CSR_POSITION_X:     position_x_ff     <= csr_data;
            CSR_POSITION_Y:     position_y_ff     <= csr_data;
            CSR_DIRECTION_X:    direction_x_ff    <= csr_data[17:0];
            CSR_DIRECTION_Y:    direction_y_ff    <= csr_data[17:0];
            CSR_CAMERA_PLANE_X: camera_plane_x_ff <= csr_data[17:0];
            CSR_CAMERA_PLANE_Y: camera_plane_y_ff <= csr_data[17:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.position_x     = position_x_ff;
   assign cfg.position_y     = position_y_ff;
   assign cfg.direction_x    = $signed(direction_x_ff);
   assign cfg.direction_y    = $signed(direction_y_ff);
   assign cfg.camera_plane_x = $signed(camera_plane_x_ff);
   assign cfg.camera_plane_y = $signed(camera_plane_y_ff);

   // Request beat.
   assign item.op            = req_op;
   assign item.screen_column = req_screen_column;
   assign item.cell_x        = req_cell_x;
   assign item.cell_y        = req_cell_y;
   assign item.cell_value    = req_cell_value;

   dda_front u_front (
      .clock     (clock),
      .reset     (reset),
      .hold      (clearing),
      .push      (req_push),
      .item      (item),
      .full      (req_full),
      .deq_valid (deq_valid),
      .deq_work  (deq_work),
      .deq_ready (deq_ready)
   );

   dda_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   dda_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .deq_valid      (deq_valid),
      .deq_work       (deq_work),
      .deq_ready      (deq_ready),
      .div_req        (div_req),
      .div_rsp        (div_rsp),
      .clearing       (clearing),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_column_out (rsp_column_out),
      .rsp_span_start (rsp_span_start),
      .rsp_span_end   (rsp_span_end),
      .rsp_wall_color (rsp_wall_color),
      .rsp_hit_side   (rsp_hit_side),
      .rsp_hit_found  (rsp_hit_found)
   );

endmodule

FILE: hdl/dda_front.sv
// ----------------------------------------------------------------------------
// DDA raycaster front queue
// Accepts request beats into a short queue and tags each as a cell write or
// a ray cast for the walk engine.
// ----------------------------------------------------------------------------
module dda_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             hold,
   input  logic             push,
   input  dda_pkg::item_type item,
   output logic             full,
   output logic             deq_valid,
   output dda_pkg::work_type deq_work,
   input  logic             deq_ready
);
   import dda_pkg::*;

   item_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_BITS-1:0]  head_ff;
   logic [QUEUE_BITS-1:0]  tail_ff;
   logic [QUEUE_BITS:0]    count_ff;
   logic                   accept;
   logic                   take;
   item_type               head_item;

   // Handshake on both sides.
   assign full      = (count_ff == (QUEUE_BITS+1)'(QUEUE_DEPTH)) | hold;
   assign accept    = push & ~full;
   assign deq_valid = (count_ff != '0);
   assign take      = deq_valid & deq_ready;

   // Classify the oldest beat.
   assign head_item               = slot_ff[head_ff];
   assign deq_work.kind           = head_item.op ? KIND_CAST : KIND_WRITE;
   assign deq_work.screen_column  = head_item.screen_column;
   assign deq_work.cell_x         = head_item.cell_x;
   assign deq_work.cell_y         = head_item.cell_y;
   assign deq_work.cell_value     = head_item.cell_value;

   // Queue pointers and count.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (accept) begin
            tail_ff <= tail_ff + 1'b1;
         end
         if (take) begin
            head_ff <= head_ff + 1'b1;
         end
         if (accept & ~take) begin
            count_ff <= count_ff + 1'b1;
         end else if (take & ~accept) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[tail_ff] <= item;
      end
   end

endmodule

FILE: hdl/dda_div.sv
// ----------------------------------------------------------------------------
// DDA raycaster divider
// Restoring divider, one quotient bit per cycle, shared by the step length
// reciprocals and the line height.
// ----------------------------------------------------------------------------
module dda_div (
   input  logic                 clock,
   input  logic                 reset,
   input  dda_pkg::div_req_type req,
   output dda_pkg::div_rsp_type rsp
);
   import dda_pkg::*;

   logic                 busy_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIST_W-1:0]    rem_ff;
   logic [DELTA_W-1:0]   dvd_ff;
   logic [DELTA_W-1:0]   quo_ff;
   logic [DIST_W-1:0]    dsr_ff;
   logic [DIST_W:0]      trial;
   logic [DIST_W:0]      diff;
   logic                 fits;

   // One trial subtraction.
   assign trial = {rem_ff, dvd_ff[DELTA_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   assign rsp.busy     = busy_ff;
   assign rsp.quotient = quo_ff;

   // Control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (req.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= '0;
         dvd_ff <= req.dividend;
         dsr_ff <= req.divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
         dvd_ff <= {dvd_ff[DELTA_W-2:0], 1'b0};
         quo_ff <= {quo_ff[DELTA_W-2:0], fits};
      end
   end

endmodule

FILE: hdl/dda_back.sv
// ----------------------------------------------------------------------------
// DDA raycaster walk engine
// Holds the grid map, sets up each ray, walks the grid one cell per step and
// check, sizes the wall span and holds the result beat for the output.
// ----------------------------------------------------------------------------
module dda_back (
   input  logic                 clock,
   input  logic                 reset,
   input  dda_pkg::cfg_type     cfg,
   input  logic                 deq_valid,
   input  dda_pkg::work_type    deq_work,
   output logic                 deq_ready,
   output dda_pkg::div_req_type div_req,
   input  dda_pkg::div_rsp_type div_rsp,
   output logic                 clearing,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [9:0]           rsp_column_out,
   output logic [8:0]           rsp_span_start,
   output logic [8:0]           rsp_span_end,
   output logic [23:0]          rsp_wall_color,
   output logic                 rsp_hit_side,
   output logic                 rsp_hit_found
);
   import dda_pkg::*;

   back_state_type            state_ff, state_in;
   logic [3:0]                grid_ff [CELL_COUNT];
   logic [ADDR_BITS-1:0]      clr_ff;
   logic [9:0]                col_ff;
   logic signed [CAM_W-1:0]   cam_ff;
   logic signed [RAY_W-1:0]   rdx_ff, rdy_ff;
   logic signed [9:0]         mx_ff, my_ff;
   logic                      negx_ff, negy_ff;
   logic [FRAC_W-1:0]         fracx_ff, fracy_ff;
   logic [DELTA_W-1:0]        ddx_ff, ddy_ff;
   logic [DELTA_W-1:0]        lox_ff, loy_ff;
   logic [DIST_W-1:0]         sdx_ff, sdy_ff, perp_ff;
   logic                      side_ff;
   logic [STEP_BITS-1:0]      steps_ff;
   logic                      out_ff;
   logic [3:0]                rd_ff;
   logic [3:0]                cell_ff;
   logic                      hit_ff;
   logic [8:0]                start_ff, end_ff;
   logic                      out_valid_ff;

   // Control outputs of the sequencer.
   logic                      mem_we;
   logic [ADDR_BITS-1:0]      mem_waddr;
   logic [3:0]                mem_wdata;
   logic                      load_out;

   // Combinational datapath.
   logic [17:0]               cam_whole;
   logic [19:0]               cam_rem;
   logic [39:0]               cam_prod;
   logic [17:0]               cam_q;
   logic signed [CAM_W-1:0]   cam_in;
   logic signed [36:0]        prod_x, prod_y;
   logic signed [RAY_W-1:0]   abs_x_s, abs_y_s;
   logic [ABS_W-1:0]          abs_x, abs_y;
   logic                      take_x;
   logic signed [9:0]         mx_n, my_n;
   logic                      outside;
   logic [ADDR_BITS-1:0]      rd_addr;
   logic [23:0]               half;
   logic [23:0]               base_color;

   // Camera x from the column.
   assign cam_whole = 18'(col_ff) * 18'(CAM_WHOLE);
   assign cam_rem   = 20'(col_ff) * 20'(CAM_REM);
   assign cam_prod  = 40'(cam_rem) * 40'(CAM_RECIP);
   assign cam_q     = cam_whole + 18'(cam_prod[39:CAM_RECIP_SHIFT]);
   assign cam_in    = $signed({1'b0, cam_q}) - $signed(CAM_W'(ONE_Q16));

   // Plane times camera x, floored to Q.16.
   assign prod_x = 37'(cfg.camera_plane_x) * 37'(cam_ff);
   assign prod_y = 37'(cfg.camera_plane_y) * 37'(cam_ff);

   // Ray direction magnitudes.
   assign abs_x_s = rdx_ff[RAY_W-1] ? -rdx_ff : rdx_ff;
   assign abs_y_s = rdy_ff[RAY_W-1] ? -rdy_ff : rdy_ff;
   assign abs_x   = abs_x_s[ABS_W-1:0];
   assign abs_y   = abs_y_s[ABS_W-1:0];

   // Next grid cell of the walk; ties step along y.
   assign take_x  = (sdx_ff < sdy_ff);
   assign mx_n    = take_x ? (negx_ff ? mx_ff - 10'sd1 : mx_ff + 10'sd1) : mx_ff;
   assign my_n    = take_x ? my_ff : (negy_ff ? my_ff - 10'sd1 : my_ff + 10'sd1);
   assign outside = mx_n[9] | (mx_n[8:0] >= 9'(MAP_SIZE))
                  | my_n[9] | (my_n[8:0] >= 9'(MAP_SIZE));
   assign rd_addr = {mx_n[MAP_BITS-1:0], my_n[MAP_BITS-1:0]};

   // Span and color.
   assign half       = div_rsp.quotient[24:1];
   assign base_color = pick_color(cell_ff);

   assign clearing  = (state_ff == BK_CLEAR);
   assign rsp_empty = ~out_valid_ff;

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and control.
   always_comb begin
      state_in         = state_ff;
      deq_ready        = 1'b0;
      mem_we           = 1'b0;
      mem_waddr        = clr_ff;
      mem_wdata        = '0;
      load_out         = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = DELTA_SAT;
      div_req.divisor  = DIST_W'(abs_x);
      case (state_ff)
         BK_CLEAR: begin
            mem_we = 1'b1;
            if (clr_ff == ADDR_BITS'(CELL_COUNT - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (deq_valid) begin
               deq_ready = 1'b1;
               if (deq_work.kind == KIND_CAST) begin
                  state_in = BK_CAM;
               end else begin
                  mem_we    = ({1'b0, deq_work.cell_x} < 6'(MAP_SIZE))
                            & ({1'b0, deq_work.cell_y} < 6'(MAP_SIZE));
                  mem_waddr = {deq_work.cell_x[MAP_BITS-1:0],
                               deq_work.cell_y[MAP_BITS-1:0]};
                  mem_wdata = deq_work.cell_value;
               end
            end
         end
         BK_CAM: begin
            state_in = BK_RAY;
         end
         BK_RAY: begin
            state_in = BK_XGO;
         end
         BK_XGO: begin
            div_req.start = 1'b1;
            state_in      = BK_XWAIT;
         end
         BK_XWAIT: begin
            if (~div_rsp.busy) begin
               state_in = BK_YGO;
            end
         end
         BK_YGO: begin
            div_req.start   = 1'b1;
            div_req.divisor = DIST_W'(abs_y);
            state_in        = BK_YWAIT;
         end
         BK_YWAIT: begin
            if (~div_rsp.busy) begin
               state_in = BK_SIDE_LO;
            end
         end
         BK_SIDE_LO: begin
            state_in = BK_SIDE_HI;
         end
         BK_SIDE_HI: begin
            state_in = BK_STEP;
         end
         BK_STEP: begin
            if (steps_ff == STEP_BITS'(STEP_LIMIT)) begin
               state_in = BK_DONE;
            end else begin
               state_in = BK_CHECK;
            end
         end
         BK_CHECK: begin
            if (out_ff) begin
               state_in = BK_DONE;
            end else if (rd_ff != 4'd0) begin
               if (perp_ff == '0) begin
                  state_in = BK_DONE;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = LINE_DIVIDEND;
                  div_req.divisor  = perp_ff;
                  state_in         = BK_LINE;
               end
            end else begin
               state_in = BK_STEP;
            end
         end
         BK_LINE: begin
            if (~div_rsp.busy) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (~out_valid_ff | rsp_pop) begin
               load_out = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Clearing pass counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (state_ff == BK_CLEAR) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // Grid map: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_ff[mem_waddr] <= mem_wdata;
      end
      rd_ff <= grid_ff[rd_addr];
   end

   // Ray setup and walk datapath.
   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            col_ff <= deq_work.screen_column;
         end
         BK_CAM: begin
            cam_ff <= cam_in;
         end
         BK_RAY: begin
            rdx_ff <= RAY_W'(cfg.direction_x) + $signed(prod_x[36:16]);
            rdy_ff <= RAY_W'(cfg.direction_y) + $signed(prod_y[36:16]);
            mx_ff  <= $signed({2'b00, cfg.position_x[23:16]});
            my_ff  <= $signed({2'b00, cfg.position_y[23:16]});
         end
         BK_XGO: begin
            negx_ff  <= rdx_ff[RAY_W-1];
            negy_ff  <= rdy_ff[RAY_W-1];
            fracx_ff <= rdx_ff[RAY_W-1] ? {1'b0, cfg.position_x[15:0]}
                      : FRAC_W'(ONE_Q16) - {1'b0, cfg.position_x[15:0]};
            fracy_ff <= rdy_ff[RAY_W-1] ? {1'b0, cfg.position_y[15:0]}
                      : FRAC_W'(ONE_Q16) - {1'b0, cfg.position_y[15:0]};
         end
         BK_XWAIT: begin
            ddx_ff <= (abs_x == '0) ? DELTA_SAT : div_rsp.quotient;
         end
         BK_YWAIT: begin
            ddy_ff <= (abs_y == '0) ? DELTA_SAT : div_rsp.quotient;
         end
         BK_SIDE_LO: begin
            lox_ff <= DELTA_W'(fracx_ff) * DELTA_W'(ddx_ff[15:0]);
            loy_ff <= DELTA_W'(fracy_ff) * DELTA_W'(ddy_ff[15:0]);
         end
         BK_SIDE_HI: begin
            sdx_ff   <= DIST_W'(34'(fracx_ff) * 34'(ddx_ff[DELTA_W-1:16]))
                      + DIST_W'(lox_ff[DELTA_W-1:16]);
            sdy_ff   <= DIST_W'(34'(fracy_ff) * 34'(ddy_ff[DELTA_W-1:16]))
                      + DIST_W'(loy_ff[DELTA_W-1:16]);
            steps_ff <= '0;
            hit_ff   <= 1'b0;
         end
         BK_STEP: begin
            if (steps_ff != STEP_BITS'(STEP_LIMIT)) begin
               if (take_x) begin
                  perp_ff <= sdx_ff;
                  sdx_ff  <= sdx_ff + DIST_W'(ddx_ff);
                  side_ff <= 1'b0;
               end else begin
                  perp_ff <= sdy_ff;
                  sdy_ff  <= sdy_ff + DIST_W'(ddy_ff);
                  side_ff <= 1'b1;
               end
               mx_ff    <= mx_n;
               my_ff    <= my_n;
               out_ff   <= outside;
               steps_ff <= steps_ff + 1'b1;
            end
         end
         BK_CHECK: begin
            if (~out_ff & (rd_ff != 4'd0)) begin
               hit_ff   <= 1'b1;
               cell_ff  <= rd_ff;
               start_ff <= '0;
               end_ff   <= 9'(SCREEN_HEIGHT - 1);
            end
         end
         BK_LINE: begin
            start_ff <= (half >= 24'(HALF_HEIGHT)) ? 9'd0
                      : 9'(24'(HALF_HEIGHT) - half);
            end_ff   <= (half >= 24'(HALF_HEIGHT)) ? 9'(SCREEN_HEIGHT - 1)
                      : 9'(half + 24'(HALF_HEIGHT));
         end
         default: begin
         end
      endcase
   end

   // Output beat valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output beat payload.
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_column_out <= col_ff;
         rsp_hit_found  <= hit_ff;
         rsp_hit_side   <= hit_ff & side_ff;
         rsp_span_start <= hit_ff ? start_ff : 9'd0;
         rsp_span_end   <= hit_ff ? end_ff : 9'd0;
         rsp_wall_color <= ~hit_ff ? 24'd0
                         : (side_ff ? {1'b0, base_color[23:1]} : base_color);
      end
   end

endmodule

FILE: sim/dda_raycast_column_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the DDA column raycaster
// Loads map cells and casts rays under a series of viewer poses. Every span
// that comes out is checked field by field against an expected span, from a
// span predictor kept in this file or written by hand. Both queue sides
// idle at random, and one long receiver stall backs the block up.
// ----------------------------------------------------------------------------
module dda_raycast_column_tb;
   import dda_pkg::*;

   typedef struct packed {
      logic [9:0]  column;
      logic [8:0]  first_row;
      logic [8:0]  last_row;
      logic [23:0] color;
      logic        side;
      logic        found;
   } span_type;

   typedef struct {
      logic        op;
      int          column;
      int          cx;
      int          cy;
      int          value;
      bit          typed;
      span_type    span;
   } row_type;

   localparam int CAST_SPLIT   = 5;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 200;
   localparam int SETTLE       = 300;
   localparam int STALL_CYCLES = 600;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_op = 1'b0;
   logic [9:0]  req_screen_column = '0;
   logic [4:0]  req_cell_x = '0;
   logic [4:0]  req_cell_y = '0;
   logic [3:0]  req_cell_value = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [9:0]  rsp_column_out;
   logic [8:0]  rsp_span_start;
   logic [8:0]  rsp_span_end;
   logic [23:0] rsp_wall_color;
   logic        rsp_hit_side;
   logic        rsp_hit_found;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_data = '0;

   // Predictor state: map cells and pose registers.
   logic [3:0]         grid_model [0:CELL_COUNT-1];
   logic [23:0]        pose_x, pose_y;
   logic signed [17:0] dir_x, dir_y, plane_x, plane_y;

   span_type pending_spans [$];
   row_type  plan [$];
   int       errors = 0;
   int       casts = 0, hits = 0, writes = 0;
   bit       calm = 1'b0;
   bit       stall_ask = 1'b0;

   dda_raycast_column u_top (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("dda_raycast_column_tb failed");
      $finish;
   end

   function automatic longint step_length(longint d);
      longint a;
      a = (d < 0) ? -d : d;
      return (a == 0) ? (longint'(1) << 32) : (longint'(1) << 32) / a;
   endfunction

   // Walks one ray through the predicted map and returns its span.
   function automatic span_type predict_span(logic [9:0] col);
      longint   cam, rdx, rdy, mx, my, ddx, ddy, sdx, sdy, perp, lh, half, top, bot;
      int       stx, sty, side, k;
      bit       hit, done;
      logic [3:0] wall;
      logic [23:0] color;
      span_type r;
      cam  = (2 * longint'(col) * ONE_Q16) / SCREEN_WIDTH - ONE_Q16;
      rdx  = longint'(dir_x) + ((longint'(plane_x) * cam) >>> 16);
      rdy  = longint'(dir_y) + ((longint'(plane_y) * cam) >>> 16);
      mx   = pose_x[23:16];
      my   = pose_y[23:16];
      ddx  = step_length(rdx);
      ddy  = step_length(rdy);
      stx  = (rdx < 0) ? -1 : 1;
      sty  = (rdy < 0) ? -1 : 1;
      sdx  = (rdx < 0) ? ((longint'(pose_x[15:0]) * ddx) >> 16)
                       : (((ONE_Q16 - longint'(pose_x[15:0])) * ddx) >> 16);
      sdy  = (rdy < 0) ? ((longint'(pose_y[15:0]) * ddy) >> 16)
                       : (((ONE_Q16 - longint'(pose_y[15:0])) * ddy) >> 16);
      perp = 0;
      side = 0;
      hit  = 0;
      done = 0;
      wall = '0;
      for (k = 0; k < STEP_LIMIT && !done; k++) begin
         // Ties step along y.
         if (sdx < sdy) begin
            perp = sdx;
            sdx += ddx;
            mx += stx;
            side = 0;
         end else begin
            perp = sdy;
            sdy += ddy;
            my += sty;
            side = 1;
         end
         if (mx < 0 || mx >= MAP_SIZE || my < 0 || my >= MAP_SIZE) begin
            done = 1;
         end else begin
            wall = grid_model[mx * MAP_SIZE + my];
            if (wall != 0) begin
               hit = 1;
               done = 1;
            end
         end
      end
      r = '0;
      r.column = col;
      if (hit) begin
         if (perp == 0) begin
            top = 0;
            bot = SCREEN_HEIGHT - 1;
         end else begin
            lh   = (longint'(SCREEN_HEIGHT) << 16) / perp;
            half = lh / 2;
            top  = (HALF_HEIGHT - half < 0) ? 0 : HALF_HEIGHT - half;
            bot  = (half + HALF_HEIGHT >= SCREEN_HEIGHT) ? SCREEN_HEIGHT - 1
                                                        : half + HALF_HEIGHT;
         end
         case (wall)
            4'd1:    color = 24'hFF0000;
            4'd2:    color = 24'h00FF00;
            4'd3:    color = 24'h0000FF;
            4'd4:    color = 24'hFFFFFF;
            default: color = 24'hFFFF00;
         endcase
         r.first_row = top[8:0];
         r.last_row  = bot[8:0];
         r.color     = (side == 1) ? color >> 1 : color;
         r.side      = side[0];
         r.found     = 1'b1;
      end
      return r;
   endfunction

   // One register beat; the predictor copy changes when the beat is taken.
   task automatic csr_write(logic [2:0] idx, logic [23:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_POSITION_X:     pose_x  = data;
         CSR_POSITION_Y:     pose_y  = data;
         CSR_DIRECTION_X:    dir_x   = data[17:0];
         CSR_DIRECTION_Y:    dir_y   = data[17:0];
         CSR_CAMERA_PLANE_X: plane_x = data[17:0];
         CSR_CAMERA_PLANE_Y: plane_y = data[17:0];
         default: ;
      endcase
   endtask

   task automatic set_pose(logic [23:0] px, logic [23:0] py, logic [17:0] dx,
                           logic [17:0] dy, logic [17:0] qx, logic [17:0] qy);
      csr_write(CSR_POSITION_X, px);
      csr_write(CSR_POSITION_Y, py);
      csr_write(CSR_DIRECTION_X, 24'(dx));
      csr_write(CSR_DIRECTION_Y, 24'(dy));
      csr_write(CSR_CAMERA_PLANE_X, 24'(qx));
      csr_write(CSR_CAMERA_PLANE_Y, 24'(qy));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Offers one request beat, with random idle cycles ahead of it.
   task automatic send_item(row_type it);
      while (!calm && $urandom_range(99) < 7) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push          <= 1'b1;
      req_op            <= it.op;
      req_screen_column <= it.column[9:0];
      req_cell_x        <= it.cx[4:0];
      req_cell_y        <= it.cy[4:0];
      req_cell_value    <= it.value[3:0];
      do @(posedge clock); while (req_full);
      if (it.op == KIND_CAST) begin
         casts++;
         pending_spans.push_back(it.typed ? it.span : predict_span(it.column[9:0]));
      end else begin
         writes++;
         grid_model[it.cx * MAP_SIZE + it.cy] = it.value[3:0];
      end
   endtask

   // Waits for every outstanding span, then for any trailing cell writes.
   task automatic drain();
      req_push <= 1'b0;
      while (pending_spans.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic row_type make_row(logic op, int col, int cx, int cy, int value);
      row_type r;
      r.op = op;
      r.column = col;
      r.cx = cx;
      r.cy = cy;
      r.value = value;
      r.typed = 1'b0;
      r.span = '0;
      return r;
   endfunction

   function automatic row_type typed_row(int col, span_type s);
      row_type r;
      r = make_row(KIND_CAST, col, 0, 0, 0);
      r.typed = 1'b1;
      r.span = s;
      return r;
   endfunction

   // Response side: random pops, one long stall on request, span checks.
   int stall_left = 0;
   bit stall_taken = 1'b0;
   int mismatches = 0;
   always @(posedge clock) begin
      span_type want, got;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = '{rsp_column_out, rsp_span_start, rsp_span_end, rsp_wall_color,
                 rsp_hit_side, rsp_hit_found};
         if (pending_spans.size() == 0) begin
            errors++;
            if (mismatches++ < 10)
               $display("unexpected span beat: column %0d", got.column);
         end else begin
            want = pending_spans.pop_front();
            if (got.found) hits++;
            if (got != want) begin
               errors++;
               if (mismatches++ < 10)
                  $display("span mismatch: want col %0d rows %0d..%0d color %h side %b hit %b, got col %0d rows %0d..%0d color %h side %b hit %b",
                           want.column, want.first_row, want.last_row, want.color,
                           want.side, want.found, got.column, got.first_row,
                           got.last_row, got.color, got.side, got.found);
            end
         end
      end
      if (stall_ask && !stall_taken) begin
         stall_taken = 1'b1;
         stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= calm ? 1'b1 : ($urandom_range(99) >= 7);
      end
   end

   initial begin
      int p, n, v;
      row_type it;
      logic [23:0] px, py;
      logic [17:0] dx, dy, qx, qy;
      span_type no_hit;
      pose_x = 0;
      pose_y = 0;
      dir_x = -18'sd65536;
      dir_y = 0;
      plane_x = 0;
      plane_y = 18'sd43254;
      for (int i = 0; i < CELL_COUNT; i++) grid_model[i] = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part. From the reset pose at the map corner looking toward
      // negative x, the first step leaves the map, so no ray hits.
      no_hit = '0;
      plan.push_back(typed_row(0, no_hit));
      no_hit.column = 639;
      plan.push_back(typed_row(639, no_hit));
      no_hit.column = 1023;
      plan.push_back(typed_row(1023, no_hit));
      plan.push_back(make_row(KIND_WRITE, 0, 0, 0, 15));
      plan.push_back(make_row(KIND_WRITE, 1023, 31, 31, 15));
      // Viewer on a grid line with a wall right in front of it: zero distance.
      plan.push_back(make_row(KIND_WRITE, 0, 15, 16, 5));
      plan.push_back(typed_row(320, '{10'd320, 9'd0, 9'd479, 24'hFFFF00, 1'b0, 1'b1}));
      plan.push_back(make_row(KIND_WRITE, 0, 15, 16, 0));
      plan.push_back(make_row(KIND_WRITE, 0, 12, 16, 1));
      plan.push_back(make_row(KIND_WRITE, 0, 16, 20, 2));
      plan.push_back(make_row(KIND_WRITE, 0, 16, 12, 3));
      plan.push_back(make_row(KIND_WRITE, 0, 20, 16, 4));
      plan.push_back(make_row(KIND_WRITE, 0, 14, 19, 9));
      plan.push_back(make_row(KIND_CAST, 320, 0, 0, 0));
      plan.push_back(make_row(KIND_CAST, 0, 31, 31, 15));
      plan.push_back(make_row(KIND_CAST, 160, 0, 0, 0));
      plan.push_back(make_row(KIND_CAST, 480, 0, 0, 0));
      plan.push_back(make_row(KIND_CAST, 639, 0, 0, 0));
      plan.push_back(make_row(KIND_CAST, 1023, 0, 0, 0));
      plan.push_back(make_row(KIND_CAST, 700, 0, 0, 0));
      foreach (plan[i]) begin
         if (i == CAST_SPLIT) begin
            drain();
            set_pose(24'h10_0000, 24'h10_8000, -18'sd65536, 18'sd0, 18'sd0, 18'sd43254);
         end
         send_item(plan[i]);
      end

      // Random phases, each under its own pose; the first three are extremes.
      for (p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            0: begin
               px = 24'hFFFFFF; py = 24'hFFFFFF;
               dx = 18'h1FFFF; dy = 18'h1FFFF; qx = 18'h20000; qy = 18'h20000;
            end
            1: begin
               px = 24'h0; py = 24'h0;
               dx = 18'h20000; dy = 18'h20000; qx = 18'h1FFFF; qy = 18'h1FFFF;
            end
            2: begin
               px = {8'd16, 16'h0}; py = {8'd16, 16'h0};
               dx = '0; dy = '0; qx = '0; qy = '0;
            end
            default: begin
               px = {8'($urandom_range(31)), 16'($urandom)};
               py = {8'($urandom_range(31)), 16'($urandom)};
               if ($urandom_range(3) == 0) px = 24'($urandom);
               dx = 18'($urandom); dy = 18'($urandom);
               qx = 18'($urandom); qy = 18'($urandom);
            end
         endcase
         set_pose(px, py, dx, dy, qx, qy);
         calm = (p == 4);
         if (p == 5) stall_ask = 1'b1;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            v = ($urandom_range(9) < 4) ? 0 : $urandom_range(15);
            it = make_row(($urandom_range(99) < 35) ? KIND_WRITE : KIND_CAST,
                          ($urandom_range(9) == 0) ? $urandom_range(1023)
                                                   : $urandom_range(639),
                          $urandom_range(31), $urandom_range(31), v);
            send_item(it);
         end
      end
      calm = 1'b0;
      drain();

      $display("Ran %0d cell writes and %0d ray casts over %0d poses; %0d spans hit a wall.",
               writes, casts, PHASES + 2, hits);
      $display("Errors: %0d.", errors);
      if (errors == 0 && pending_spans.size() == 0)
         $display("dda_raycast_column_tb passed");
      else
         $display("dda_raycast_column_tb failed");
      $finish;
   end

endmodule
